>>> hdl/cube_map_face_select_defines.svh
// Assertion macros used by the checker file.
`ifndef CUBE_MAP_FACE_SELECT_DEFINES_SVH
`define CUBE_MAP_FACE_SELECT_DEFINES_SVH

// Implication in the same cycle.
`define CMFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cube map face select: check failed");

// Implication into the following cycle.
`define CMFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cube map face select: check failed");

`endif

>>> hdl/cmfs_pkg.sv
package cmfs_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int QW = COORD_FRAC_BITS + 1;
	localparam int DW = 17;
	localparam int RW = 18;
	localparam int TEX_W = 17;

	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	localparam logic [TEX_W-1:0] TEX_HALF = TEX_W'(64'd1 << (COORD_FRAC_BITS - 1));

	typedef struct packed {
		logic [2:0]    face;
		logic          zero;
		logic [DW-1:0] den;
		logic [RW-1:0] rem_u;
		logic [RW-1:0] rem_v;
		logic [QW-1:0] quo_u;
		logic [QW-1:0] quo_v;
	} cmfs_item_t;

endpackage

>>> hdl/cmfs_front.sv
module cmfs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         dir_x,
	input  logic [15:0]         dir_y,
	input  logic [15:0]         dir_z,
	output logic                out_valid,
	input  logic                out_ready,
	output cmfs_pkg::cmfs_item_t out_item
);

	logic signed [16:0] xe, ye, ze;
	logic [16:0] ax, ay, az;
	logic signed [16:0] su, sv;
	logic [16:0] ma;
	logic [2:0] face_w;
	logic zero_w;
	logic signed [17:0] nu_w, nv_w;
	logic [16:0] nu, nv, den_w;
	logic bu, bv;
	logic valid_s1;
	cmfs_pkg::cmfs_item_t item_s1;
	cmfs_pkg::cmfs_item_t item_w;

	always_comb begin
		xe = {dir_x[15], dir_x};
		ye = {dir_y[15], dir_y};
		ze = {dir_z[15], dir_z};
		ax = xe[16] ? 17'(-xe) : 17'(xe);
		ay = ye[16] ? 17'(-ye) : 17'(ye);
		az = ze[16] ? 17'(-ze) : 17'(ze);
		zero_w = (ax == 17'd0) && (ay == 17'd0) && (az == 17'd0);
		if (zero_w) begin
			face_w = cmfs_pkg::FACE_NEG_Z;
			ma = 17'd1;
			su = '0;
			sv = '0;
		end else if ((ax >= ay) && (ax >= az)) begin
			ma = ax;
			sv = -ye;
			if (!xe[16] && (xe != 17'sd0)) begin
				face_w = cmfs_pkg::FACE_POS_X;
				su = -ze;
			end else begin
				face_w = cmfs_pkg::FACE_NEG_X;
				su = ze;
			end
		end else if (ay >= az) begin
			ma = ay;
			su = xe;
			if (!ye[16] && (ye != 17'sd0)) begin
				face_w = cmfs_pkg::FACE_POS_Y;
				sv = ze;
			end else begin
				face_w = cmfs_pkg::FACE_NEG_Y;
				sv = -ze;
			end
		end else begin
			ma = az;
			sv = -ye;
			if (!ze[16] && (ze != 17'sd0)) begin
				face_w = cmfs_pkg::FACE_POS_Z;
				su = xe;
			end else begin
				face_w = cmfs_pkg::FACE_NEG_Z;
				su = -xe;
			end
		end
		nu_w = $signed({su[16], su}) + $signed({1'b0, ma});
		nv_w = $signed({sv[16], sv}) + $signed({1'b0, ma});
		nu = nu_w[16:0];
		nv = nv_w[16:0];
		den_w = {ma[15:0], 1'b0};
		bu = (nu >= den_w);
		bv = (nv >= den_w);
		item_w.face = face_w;
		item_w.zero = zero_w;
		item_w.den = den_w;
		item_w.rem_u = bu ? '0 : {1'b0, nu};
		item_w.rem_v = bv ? '0 : {1'b0, nv};
		item_w.quo_u = {{(cmfs_pkg::QW-1){1'b0}}, bu};
		item_w.quo_v = {{(cmfs_pkg::QW-1){1'b0}}, bv};
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_w;
		end
	end

	assign out_valid = valid_s1;
	assign out_item = item_s1;

endmodule

>>> hdl/cmfs_div_cell.sv
module cmfs_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cmfs_pkg::cmfs_item_t in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cmfs_pkg::cmfs_item_t out_item
);

	logic [cmfs_pkg::RW-1:0] ru2, rv2, dext;
	logic bu, bv;
	logic valid_q;
	cmfs_pkg::cmfs_item_t item_q;
	cmfs_pkg::cmfs_item_t item_w;

	always_comb begin
		dext = {1'b0, in_item.den};
		ru2 = {in_item.rem_u[cmfs_pkg::RW-2:0], 1'b0};
		rv2 = {in_item.rem_v[cmfs_pkg::RW-2:0], 1'b0};
		bu = (ru2 >= dext);
		bv = (rv2 >= dext);
		item_w = in_item;
		item_w.rem_u = bu ? (ru2 - dext) : ru2;
		item_w.rem_v = bv ? (rv2 - dext) : rv2;
		item_w.quo_u = {in_item.quo_u[cmfs_pkg::QW-2:0], bu};
		item_w.quo_v = {in_item.quo_v[cmfs_pkg::QW-2:0], bv};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_w;
		end
	end

	assign out_valid = valid_q;
	assign out_item = item_q;

endmodule

>>> hdl/cube_map_face_select.sv
// Channel  Handshake            Payload
// request  in_valid, in_stall   dir_x, dir_y, dir_z
// result   out_valid, out_stall face, tex_u, tex_v, zero_vector
//
// One request is accepted every cycle while in_stall is low.
// Each request passes the axis select stage and then one restoring division cell per fraction bit.
// Reset clears only the valid bit of every stage.
// A stalled result holds its stage; earlier stages keep filling any empty slots ahead of them.
module cube_map_face_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] dir_x,
	input  logic [15:0] dir_y,
	input  logic [15:0] dir_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  face,
	output logic [16:0] tex_u,
	output logic [16:0] tex_v,
	output logic        zero_vector
);

	localparam int NC = cmfs_pkg::COORD_FRAC_BITS;

	logic front_ready;
	logic [NC:0] stg_valid;
	logic [NC:0] stg_ready;
	cmfs_pkg::cmfs_item_t stg_item [NC+1];

	cmfs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (front_ready),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.out_valid(stg_valid[0]),
		.out_ready(stg_ready[0]),
		.out_item (stg_item[0])
	);

	for (genvar i = 0; i < NC; i++) begin : g_cell
		cmfs_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stg_valid[i]),
			.in_ready (stg_ready[i]),
			.in_item  (stg_item[i]),
			.out_valid(stg_valid[i+1]),
			.out_ready(stg_ready[i+1]),
			.out_item (stg_item[i+1])
		);
	end

	assign stg_ready[NC] = !out_stall;
	assign in_stall = !front_ready;

	assign out_valid = stg_valid[NC];
	assign face = stg_item[NC].face;
	assign zero_vector = stg_item[NC].zero;
	assign tex_u = cmfs_pkg::TEX_W'(stg_item[NC].quo_u);
	assign tex_v = cmfs_pkg::TEX_W'(stg_item[NC].quo_v);

endmodule

>>> hdl/cmfs_checker.sv
`include "cube_map_face_select_defines.svh"

module cmfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  face,
	input logic [16:0] tex_u,
	input logic [16:0] tex_v,
	input logic        zero_vector
);

	`CMFS_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)
	`CMFS_ASSERT_NEXT(a_hold_data, clk, arst_n, out_valid && out_stall, $stable(face) && $stable(tex_u) && $stable(tex_v) && $stable(zero_vector))
	`CMFS_ASSERT_NOW(a_face_range, clk, arst_n, out_valid, face <= cmfs_pkg::FACE_NEG_Z)
	`CMFS_ASSERT_NOW(a_zero_result, clk, arst_n, out_valid && zero_vector, (face == cmfs_pkg::FACE_NEG_Z) && (tex_u == cmfs_pkg::TEX_HALF) && (tex_v == cmfs_pkg::TEX_HALF))

endmodule

bind cube_map_face_select cmfs_checker u_cmfs_checker (.*);
